// File: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int TOTAL   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(TOTAL);

	// Largest divisor seen by the remainder unit: a row length or a tab width
	localparam int TAB_MAX = 127;
	localparam int DIV_MAX = (COLUMNS > TAB_MAX) ? COLUMNS : TAB_MAX;
	localparam int DIV_W   = $clog2(DIV_MAX + 1);

	// Cursor must hold a row or tab advance past the last cell before scrolling
	localparam int CUR_W   = $clog2(TOTAL + DIV_MAX + 1);
	localparam int CNT_W   = $clog2(CUR_W + 1);

	// Stream and port widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CELL_W     = 16;

	// Character codes
	localparam logic [7:0]  BLANK_CHAR = 8'h20;
	localparam logic [7:0]  BAD_CHAR   = 8'h3F;
	localparam logic [7:0]  RESET_ATTR = 8'h07;
	localparam logic [15:0] CH_LF      = 16'h000A;
	localparam logic [15:0] CH_CR      = 16'h000D;
	localparam logic [15:0] CH_TAB     = 16'h0009;

	// Operation codes
	localparam logic [2:0] FN_CON    = 3'd0;
	localparam logic [2:0] FN_RAW    = 3'd1;
	localparam logic [2:0] FN_CLEAR  = 3'd2;
	localparam logic [2:0] FN_SCROLL = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAB   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW   = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_REM,
		ST_CHECK,
		ST_SWEEP,
		ST_BLANK,
		ST_PUSH
	} state_t;

	// Source of a sweep write
	typedef enum logic [1:0] {
		WS_MEM,
		WS_BLANK,
		WS_RESET
	} wr_src_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
	} ram_wr_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] rem;
	} rem_res_t;

endpackage

// File: src/tcw_screen_ram.sv
`timescale 1ns / 1ps

module tcw_screen_ram (
	input  logic                          clk,
	input  tcw_pkg::ram_wr_t              wr,
	input  logic [tcw_pkg::ADDR_W-1:0]    raddr,
	output logic [tcw_pkg::CELL_W-1:0]    rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [TOTAL];

	// Write one cell, read one cell with registered data
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/tcw_rem.sv
`timescale 1ns / 1ps

module tcw_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tcw_pkg::CUR_W-1:0]   dividend,
	input  logic [tcw_pkg::DIV_W-1:0]   divisor,
	output tcw_pkg::rem_res_t           res
);
	import tcw_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CUR_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, dvd_q[CUR_W-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	// Sequence the steps, one dividend bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(CUR_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Hold the operands and the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CUR_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

// File: src/text_console_writer.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit up)
// s_*       in   tuser: func[2:0]; tdata: char_code[15:0], cell_index[26:16]
// m_*       out  tdata: cursor_cell[10:0], read_char[18:11], read_attr[26:19],
//                       scrolled[27]
// cfg_*     in   cfg_index selects tab_width, blank_attribute, raw_attribute
//
// One item at a time. A printable console character reads its cell and writes
// it back, a raw write writes its cell, a read fetches one, newline and tab run
// the remainder unit (one remainder step per cursor bit). A scroll walks every
// cell once through the screen memory's one read and one write port; clear
// blanks every cell. After reset a clearing pass fills the screen; no item is
// taken meanwhile. A stalled result holds in the output register while the next
// item is accepted; that item waits at its end until the register frees.

module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tcw_pkg::IN_DATA_W-1:0]     s_tdata,   // char_code, cell_index
	input  logic [tcw_pkg::IN_USER_W-1:0]     s_tuser,   // func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tcw_pkg::OUT_DATA_W-1:0]    m_tdata,   // cursor_cell, read_char,
	                                                     // read_attr, scrolled
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tcw_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [CUR_W-1:0]  cursor_q, cursor_d;
	logic              scr_q, scr_d;
	logic [7:0]        rchar_q, rchar_d;
	logic [7:0]        rattr_q, rattr_d;

	logic [2:0]        func_q;
	logic [15:0]       code_q;
	logic [10:0]       idx_q;

	logic [6:0]        tab_q;
	logic [7:0]        blank_attr_q;
	logic [7:0]        raw_attr_q;

	logic              wv_s1;
	logic [ADDR_W-1:0] waddr_s1;
	wr_src_t           wsrc_s1;

	logic              iss_v;
	wr_src_t           iss_src;
	ram_wr_t           dwr;
	ram_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] rdata;

	logic              rem_start;
	logic [DIV_W-1:0]  rem_div;
	rem_res_t          rem_res;

	logic              load_out;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [7:0]        char_b;
	logic [DIV_W-1:0]  tab_eff;
	logic              in_acc;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign char_b   = (code_q > 16'd255) ? BAD_CHAR : code_q[7:0];
	assign tab_eff  = (tab_q == 7'd0) ? DIV_W'(1) : DIV_W'(tab_q);
	assign rem_div  = (code_q == CH_LF) ? DIV_W'(COLUMNS) : tab_eff;

	// Sequence one operation
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		cursor_d  = cursor_q;
		scr_d     = scr_q;
		rchar_d   = rchar_q;
		rattr_d   = rattr_q;
		raddr     = cursor_q[ADDR_W-1:0];
		dwr       = '0;
		iss_v     = 1'b0;
		iss_src   = WS_MEM;
		rem_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_INIT: begin
				iss_v   = 1'b1;
				iss_src = WS_RESET;
				if (ptr_q == ADDR_W'(TOTAL - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					scr_d   = 1'b0;
					rchar_d = '0;
					rattr_d = '0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (func_q)
					FN_CON: begin
						if (code_q == CH_LF || code_q == CH_TAB) begin
							rem_start = 1'b1;
							state_d   = ST_REM;
						end else if (code_q == CH_CR) begin
							state_d = ST_CHECK;
						end else if (cursor_q < CUR_W'(TOTAL)) begin
							state_d = ST_RD;
						end else begin
							cursor_d = cursor_q + 1'b1;
							state_d  = ST_CHECK;
						end
					end
					FN_RAW: begin
						if (cursor_q < CUR_W'(TOTAL)) begin
							dwr.we    = 1'b1;
							dwr.waddr = cursor_q[ADDR_W-1:0];
							dwr.wdata = {raw_attr_q, char_b};
							cursor_d  = cursor_q + 1'b1;
						end
						state_d = ST_PUSH;
					end
					FN_CLEAR: begin
						cursor_d = '0;
						ptr_d    = '0;
						state_d  = ST_BLANK;
					end
					FN_SCROLL: begin
						scr_d    = 1'b1;
						cursor_d = CUR_W'(TOTAL - COLUMNS);
						ptr_d    = '0;
						state_d  = ST_SWEEP;
					end
					FN_READ: begin
						if (idx_q < 11'(TOTAL)) begin
							raddr   = ADDR_W'(idx_q);
							state_d = ST_RD;
						end else begin
							state_d = ST_PUSH;
						end
					end
					default: begin
						state_d = ST_PUSH;
					end
				endcase
			end
			ST_RD: begin
				if (func_q == FN_READ) begin
					rchar_d = rdata[7:0];
					rattr_d = rdata[15:8];
					state_d = ST_PUSH;
				end else begin
					// Keep the cell's attribute, replace its character
					dwr.we    = 1'b1;
					dwr.waddr = cursor_q[ADDR_W-1:0];
					dwr.wdata = {rdata[15:8], char_b};
					cursor_d  = cursor_q + 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_REM: begin
				if (rem_res.done) begin
					cursor_d = cursor_q - CUR_W'(rem_res.rem) + CUR_W'(rem_div);
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cursor_q >= CUR_W'(TOTAL)) begin
					scr_d    = 1'b1;
					cursor_d = CUR_W'(TOTAL - COLUMNS);
					ptr_d    = '0;
					state_d  = ST_SWEEP;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_SWEEP: begin
				// Read one row ahead, write it back in the next cycle
				raddr   = ADDR_W'(ptr_q + ADDR_W'(COLUMNS));
				iss_v   = 1'b1;
				iss_src = WS_MEM;
				if (ptr_q == ADDR_W'(TOTAL - COLUMNS - 1)) begin
					ptr_d   = ADDR_W'(TOTAL - COLUMNS);
					state_d = ST_BLANK;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_BLANK: begin
				iss_v   = 1'b1;
				iss_src = WS_BLANK;
				if (ptr_q == ADDR_W'(TOTAL - 1)) begin
					ptr_d   = '0;
					state_d = ST_PUSH;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_PUSH: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Merge sweep writes and single-cell writes onto the one write port
	always_comb begin
		wr = dwr;
		if (wv_s1) begin
			wr.we    = 1'b1;
			wr.waddr = waddr_s1;
			case (wsrc_s1)
				WS_MEM:   wr.wdata = rdata;
				WS_BLANK: wr.wdata = {blank_attr_q, BLANK_CHAR};
				WS_RESET: wr.wdata = {RESET_ATTR, BLANK_CHAR};
				default:  wr.wdata = rdata;
			endcase
		end
	end

	// Advance control state, take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			ptr_q        <= '0;
			cursor_q     <= '0;
			wv_s1        <= 1'b0;
			m_valid_q    <= 1'b0;
			tab_q        <= 7'd4;
			blank_attr_q <= RESET_ATTR;
			raw_attr_q   <= RESET_ATTR;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			cursor_q <= cursor_d;
			wv_s1    <= iss_v;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TAB:   tab_q        <= cfg_data[6:0];
					CFG_BLANK: blank_attr_q <= cfg_data;
					CFG_RAW:   raw_attr_q   <= cfg_data;
					default:   ;
				endcase
			end
		end
	end

	// Hold the item, the sweep stage and the result payload
	always_ff @(posedge clk) begin
		scr_q    <= scr_d;
		rchar_q  <= rchar_d;
		rattr_q  <= rattr_d;
		waddr_s1 <= ptr_q;
		wsrc_s1  <= iss_src;
		if (in_acc) begin
			func_q <= s_tuser;
			code_q <= s_tdata[15:0];
			idx_q  <= s_tdata[26:16];
		end
		if (load_out) begin
			m_data_q <= {4'd0, scr_q, rattr_q, rchar_q, 11'(cursor_q)};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	tcw_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cursor_q),
		.divisor  (rem_div),
		.res      (rem_res)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tcw_pkg::*;

	localparam logic [2:0] FN_TOP = 3'd7;
	localparam int SEND_BEATS = 108;
	localparam int NUM_PHASES = 6;
	localparam int NUM_ROWS = 24;

	// one result item as it sits in m_tdata[27:0]
	typedef struct packed {
		logic        scrolled;
		logic [7:0]  attr;
		logic [7:0]  chr;
		logic [10:0] cursor;
	} console_result_t;

	// one directed row: the item, and the result where it is known up front
	typedef struct packed {
		logic [2:0]      op;
		logic [15:0]     code;
		logic [10:0]     cell_idx;
		logic            known;
		console_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // char_code[15:0], cell_index[26:16]
	logic [IN_USER_W-1:0] s_tuser;   // func[2:0]
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // cursor_cell[10:0], read_char[18:11],
	                                 // read_attr[26:19], scrolled[27]
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the screen, cursor and registers
	logic [15:0] screen [TOTAL];
	int          mirror_cursor;
	logic [6:0]  tab_width;
	logic [7:0]  blank_attr;
	logic [7:0]  raw_attr;

	console_result_t pending_results [$];
	int mismatch_count = 0;
	int send_idle_pct = 12;
	int recv_idle_pct = 61;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{FN_READ,   16'h0000, 11'd0,    1'b1, '{1'b0, 8'h07, 8'h20, 11'd0}},
		'{FN_READ,   16'h0000, 11'd1999, 1'b1, '{1'b0, 8'h07, 8'h20, 11'd0}},
		'{FN_READ,   16'hFFFF, 11'd2000, 1'b1, '{1'b0, 8'h00, 8'h00, 11'd0}},
		'{FN_READ,   16'h0000, 11'd2047, 1'b1, '{1'b0, 8'h00, 8'h00, 11'd0}},
		'{FN_CON,    16'h0041, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd1}},
		'{FN_CON,    16'hFFFF, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd2}},
		'{FN_CON,    CH_CR,    11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd2}},
		'{FN_CON,    CH_TAB,   11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd4}},
		'{FN_CON,    CH_LF,    11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd80}},
		'{FN_RAW,    16'h0000, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd81}},
		'{FN_RAW,    16'h01FF, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd82}},
		'{FN_RAW,    16'h00FF, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd83}},
		'{FN_READ,   16'h0000, 11'd1,    1'b1, '{1'b0, 8'h07, 8'h3F, 11'd83}},
		'{FN_READ,   16'h0000, 11'd80,   1'b1, '{1'b0, 8'h07, 8'h00, 11'd83}},
		'{FN_CON,    16'h0100, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd84}},
		'{3'd5,      16'hFFFF, 11'd2047, 1'b1, '{1'b0, 8'h00, 8'h00, 11'd84}},
		'{3'd6,      16'h0000, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd84}},
		'{FN_TOP,    16'hAAAA, 11'h555,  1'b1, '{1'b0, 8'h00, 8'h00, 11'd84}},
		'{FN_SCROLL, 16'h0000, 11'd0,    1'b1, '{1'b1, 8'h00, 8'h00, 11'd1920}},
		'{FN_READ,   16'h0000, 11'd0,    1'b0, '0},
		'{FN_READ,   16'h0000, 11'd1920, 1'b1, '{1'b0, 8'h07, 8'h20, 11'd1920}},
		'{FN_CON,    CH_LF,    11'd0,    1'b1, '{1'b1, 8'h00, 8'h00, 11'd1920}},
		'{FN_CLEAR,  16'h5555, 11'd0,    1'b1, '{1'b0, 8'h00, 8'h00, 11'd0}},
		'{FN_READ,   16'h0000, 11'd3,    1'b0, '0}
	};

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shift the screen up a row and blank the bottom row
	function automatic void scroll_screen();
		for (int i = 0; i < TOTAL - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = TOTAL - COLUMNS; i < TOTAL; i++)
			screen[i] = {blank_attr, BLANK_CHAR};
		mirror_cursor = TOTAL - COLUMNS;
	endfunction

	// apply one item to the mirror and return the result it gives
	function automatic console_result_t advance_console(logic [2:0] op, logic [15:0] code,
			logic [10:0] cell_idx);
		console_result_t r;
		int stop;
		logic [7:0] char_val;
		r = '0;
		char_val = (code > 16'd255) ? BAD_CHAR : code[7:0];
		case (op)
			FN_CON: begin
				if (code == CH_LF) begin
					mirror_cursor = mirror_cursor / COLUMNS * COLUMNS + COLUMNS;
				end else if (code == CH_TAB) begin
					stop = (tab_width == 0) ? 1 : tab_width;
					mirror_cursor = mirror_cursor / stop * stop + stop;
				end else if (code != CH_CR) begin
					// keep the cell's attribute; past the end nothing is stored
					if (mirror_cursor < TOTAL)
						screen[mirror_cursor][7:0] = char_val;
					mirror_cursor = mirror_cursor + 1;
				end
				if (mirror_cursor >= TOTAL) begin
					scroll_screen();
					r.scrolled = 1'b1;
				end
			end
			FN_RAW: begin
				if (mirror_cursor < TOTAL) begin
					screen[mirror_cursor] = {raw_attr, char_val};
					mirror_cursor = mirror_cursor + 1;
				end
			end
			FN_CLEAR: begin
				for (int i = 0; i < TOTAL; i++)
					screen[i] = {blank_attr, BLANK_CHAR};
				mirror_cursor = 0;
			end
			FN_SCROLL: begin
				scroll_screen();
				r.scrolled = 1'b1;
			end
			FN_READ: begin
				if (cell_idx < TOTAL)
					{r.attr, r.chr} = screen[cell_idx];
			end
			default: begin
			end
		endcase
		r.cursor = 11'(mirror_cursor);
		return r;
	endfunction

	// present one item from a falling edge, hold it until taken, log its result
	task automatic send_item(logic [2:0] op, logic [15:0] code, logic [10:0] cell_idx,
			logic known = 1'b0, console_result_t known_res = '0);
		console_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, cell_idx, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = advance_console(op, code, cell_idx);
		pending_results.push_back(known ? known_res : r);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_TAB:   tab_width  = value[6:0];
			CFG_BLANK: blank_attr = value;
			CFG_RAW:   raw_attr   = value;
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// wait for every result to come back, then settle
	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] console_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 12)
			return CH_LF;
		else if (pick < 16)
			return CH_CR;
		else if (pick < 24)
			return CH_TAB;
		else if (pick < 85)
			return 16'($urandom_range(255));
		return 16'($urandom_range(65535));
	endfunction

	// fill the bottom row with raw items up to the end, then poke past it
	task automatic fill_to_end(inout int sent);
		int tail;
		send_item(FN_SCROLL, 16'($urandom), 11'($urandom));
		for (int i = 0; i < COLUMNS; i++)
			send_item(FN_RAW, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(255)),
				11'($urandom));
		tail = $urandom_range(3, 1);
		for (int i = 0; i < tail; i++) begin
			case ($urandom_range(3))
				0: send_item(FN_RAW, 16'($urandom_range(255)), 11'($urandom));
				1: send_item(FN_CON, console_code(), 11'($urandom));
				2: send_item(FN_CON, CH_CR, 11'($urandom));
				default: send_item(FN_READ, 16'($urandom),
					11'(TOTAL - COLUMNS + $urandom_range(COLUMNS - 1)));
			endcase
		end
		sent += COLUMNS + 1 + tail;
	endtask

	task automatic run_random(int target, logic force_fill);
		int sent;
		int pick;
		sent = 0;
		if (force_fill)
			fill_to_end(sent);
		while (sent < target) begin
			pick = $urandom_range(999);
			if (pick < 5) begin
				fill_to_end(sent);
			end else if (pick < 920) begin
				if (pick < 550)
					send_item(FN_CON, console_code(), 11'($urandom));
				else if (pick < 750)
					send_item(FN_RAW, ($urandom_range(9) == 0) ? 16'($urandom)
						: 16'($urandom_range(255)), 11'($urandom));
				else if (pick < 880)
					send_item(FN_READ, 16'($urandom), ($urandom_range(6) == 0)
						? 11'($urandom_range(2047)) : 11'($urandom_range(TOTAL - 1)));
				else if (pick < 900)
					send_item(FN_CLEAR, 16'($urandom), 11'($urandom));
				else
					send_item(FN_SCROLL, 16'($urandom), 11'($urandom));
				sent++;
			end else begin
				// unused codes change nothing
				send_item(3'($urandom_range(FN_TOP, FN_READ + 1)), 16'($urandom), 11'($urandom));
				sent++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// receiver stalls at random
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic note_failure(string what, console_result_t want, console_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected cursor %0d char %h attr %h scrolled %b, got cursor %0d char %h attr %h scrolled %b",
				what, want.cursor, want.chr, want.attr, want.scrolled,
				got.cursor, got.chr, got.attr, got.scrolled);
	endtask

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : check_results
		console_result_t want;
		console_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[27:0];
			if (pending_results.size() == 0) begin
				note_failure("result with nothing pending", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.cursor != want.cursor || got.chr != want.chr ||
						got.attr != want.attr || got.scrolled != want.scrolled)
					note_failure("result mismatch", want, got);
			end
		end
	end

	initial begin
		int tab_set [NUM_PHASES] = '{1, 80, 0, 127, 8, 0};
		int blank_set [3] = '{8'h00, 8'hFF, 8'hA5};
		int raw_set [3] = '{8'hFF, 8'h00, 8'h5A};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int i = 0; i < TOTAL; i++)
			screen[i] = {RESET_ATTR, BLANK_CHAR};
		mirror_cursor = 0;
		tab_width  = 7'd4;
		blank_attr = RESET_ATTR;
		raw_attr   = RESET_ATTR;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hold off until the clearing pass after reset is done
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);

		// directed rows under reset settings
		for (int i = 0; i < NUM_ROWS; i++)
			send_item(directed_rows[i].op, directed_rows[i].code, directed_rows[i].cell_idx,
				directed_rows[i].known, directed_rows[i].res);
		s_tvalid <= 1'b0;
		drain();

		// random phases, each under its own register settings; the idle pattern changes at phases 2 and 4
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 61;
				recv_idle_pct = 12;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(CFG_TAB, 8'((p == NUM_PHASES - 1) ? $urandom_range(COLUMNS, 1) : tab_set[p]));
			write_reg(CFG_BLANK, 8'((p < 3) ? blank_set[p] : $urandom_range(255)));
			write_reg(CFG_RAW, 8'((p < 3) ? raw_set[p] : $urandom_range(255)));
			cfg_we <= 1'b0;
			run_random(SEND_BEATS, p == 1);
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// give up if the block stops answering
	initial begin
		#80_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/tcw_rem.sv
src/text_console_writer.sv
test/tb_top.sv
